@@ rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the base64 stream decoder.
// No dependencies; imported by every module of the block.
package b64d_pkg;

  // Depth of the queue between classifier and decode engine
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = 1;

  // Reset value of the output capacity register
  localparam logic [15:0] CapReset = 16'hC000;

  // Completion status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadLen  = 2'd1;
  localparam logic [1:0] StTooSmall = 2'd2;
  localparam logic [1:0] StBadChar = 2'd3;

  // One classified character as it waits in the queue
  typedef struct packed {
    logic       last;
    logic       pad;
    logic       bad;
    logic [5:0] val;
  } b64d_sym_t;

  // Queue occupancy seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // One result item held in the output register
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] byte_count;
  } b64d_res_t;

endpackage

@@ rtl/b64d_queue.sv @@
`timescale 1ns / 1ps
// Short register queue between the classifier and the decode engine.
// Depends on b64d_pkg for the entry type and depth.
module b64d_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  b64d_pkg::b64d_sym_t  wdata_i,
  input  logic                 pop_i,
  output b64d_pkg::b64d_sym_t  rdata_o,
  output b64d_pkg::b64d_qstat_t stat_o
);
  import b64d_pkg::*;

  b64d_sym_t      mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   cnt_q, cnt_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry on a push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o     = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == (QAw+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

@@ rtl/b64d_front.sv @@
`timescale 1ns / 1ps
// Input side: accepts characters and classifies them as value, padding or invalid.
// Depends on b64d_pkg; feeds b64d_queue.
module b64d_front (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,
  input  b64d_pkg::b64d_qstat_t qstat_i,
  output logic                  push_o,
  output b64d_pkg::b64d_sym_t   entry_o
);
  import b64d_pkg::*;

  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpZ  = 8'h5A;
  localparam logic [7:0] ChLoA  = 8'h61;
  localparam logic [7:0] ChLoZ  = 8'h7A;
  localparam logic [7:0] ChDig0 = 8'h30;
  localparam logic [7:0] ChDig9 = 8'h39;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPad  = 8'h3D;

  logic [7:0] sym;
  logic [7:0] val8;

  assign sym = s_axis_tdata_i;

  // Map the character to its 6-bit value or a class flag
  always_comb begin
    val8         = '0;
    entry_o.pad  = 1'b0;
    entry_o.bad  = 1'b0;
    if (sym inside {[ChUpA:ChUpZ]}) begin
      val8 = sym - ChUpA;
    end else if (sym inside {[ChLoA:ChLoZ]}) begin
      val8 = sym - ChLoA + 8'd26;
    end else if (sym inside {[ChDig0:ChDig9]}) begin
      val8 = sym - ChDig0 + 8'd52;
    end else if (sym == ChPlus) begin
      val8 = 8'd62;
    end else if (sym == ChSlash) begin
      val8 = 8'd63;
    end else if (sym == ChPad) begin
      entry_o.pad = 1'b1;
    end else begin
      entry_o.bad = 1'b1;
    end
    entry_o.val  = val8[5:0];
    entry_o.last = s_axis_tlast_i;
  end

  // Take a transfer whenever the queue has room
  assign s_axis_tready_o = !qstat_i.full;
  assign push_o          = s_axis_tvalid_i && !qstat_i.full;

endmodule

@@ rtl/b64d_back.sv @@
`timescale 1ns / 1ps
// Decode engine: bit accumulator, counters, completion status and output register.
// Depends on b64d_pkg; drains b64d_queue.
module b64d_back #(
  parameter int unsigned MaxChars = 65536,
  parameter int unsigned Cw       = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  b64d_pkg::b64d_qstat_t qstat_i,
  input  b64d_pkg::b64d_sym_t   entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output b64d_pkg::b64d_res_t   res_o
);
  import b64d_pkg::*;

  localparam int unsigned Nw = (Cw + 1 > 17) ? Cw + 1 : 17;

  logic [15:0]   cap_q;
  logic [11:0]   acc_q, acc_d;
  logic [2:0]    pend_q, pend_d;
  logic [Cw-1:0] cc_q, cc_d;
  logic          prev_pad_q, prev_pad_d;
  logic          bad_seen_q, bad_seen_d;
  logic [15:0]   bw_q, bw_d;
  logic          out_valid_q, out_valid_d;
  b64d_res_t     res_q, res_d;

  logic [3:0]    pend6;
  logic [11:0]   acc_sh;
  logic [Cw-1:0] total;
  logic [1:0]    pad_cnt;
  logic [Nw-1:0] quar;
  logic [Nw-1:0] need;

  // Pop whenever the output register is free or being emptied
  assign pop_o = !qstat_i.empty && (!out_valid_q || out_ready_i);

  // Per-character update of the stream state
  always_comb begin
    acc_d      = acc_q;
    pend_d     = pend_q;
    bad_seen_d = bad_seen_q;
    bw_d       = bw_q;
    res_d      = '0;
    pend6      = {1'b0, pend_q} + 4'd6;
    acc_sh     = '0;

    cc_d  = (cc_q <= Cw'(MaxChars)) ? cc_q + 1'b1 : cc_q;
    total = cc_d;

    if (entry_i.bad) begin
      bad_seen_d = 1'b1;
    end else if (!entry_i.pad && !bad_seen_q) begin
      acc_d = {acc_q[5:0], entry_i.val};
      if (pend6 >= 4'd8) begin
        pend_d = 3'(pend6 - 4'd8);
        if (bw_q < cap_q) begin
          acc_sh           = acc_d >> pend_d;
          res_d.data_byte  = acc_sh[7:0];
          res_d.byte_valid = 1'b1;
          bw_d             = bw_q + 1'b1;
        end
      end else begin
        pend_d = pend6[2:0];
      end
    end

    // Padded decoded size from the total length
    pad_cnt = {1'b0, entry_i.pad} + {1'b0, prev_pad_q};
    quar    = Nw'(total >> 2);
    need    = quar + (quar << 1) - Nw'(pad_cnt);

    prev_pad_d = entry_i.pad;

    // Close the string: status by priority, then clear
    if (entry_i.last) begin
      res_d.done_res = 1'b1;
      if (total < Cw'(4) || total[1:0] != 2'b00 || total > Cw'(MaxChars)) begin
        res_d.status = StBadLen;
      end else if (Nw'(cap_q) < need) begin
        res_d.status     = StTooSmall;
        res_d.byte_count = (need > Nw'(16'hFFFF)) ? 16'hFFFF : need[15:0];
      end else if (bad_seen_d) begin
        res_d.status = StBadChar;
      end else begin
        res_d.status     = StOk;
        res_d.byte_count = bw_d;
      end
      acc_d      = '0;
      pend_d     = '0;
      cc_d       = '0;
      prev_pad_d = 1'b0;
      bad_seen_d = 1'b0;
      bw_d       = '0;
    end
  end

  // Hold a result until it is taken
  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      acc_q       <= '0;
      pend_q      <= '0;
      cc_q        <= '0;
      prev_pad_q  <= 1'b0;
      bad_seen_q  <= 1'b0;
      bw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        acc_q      <= acc_d;
        pend_q     <= pend_d;
        cc_q       <= cc_d;
        prev_pad_q <= prev_pad_d;
        bad_seen_q <= bad_seen_d;
        bw_q       <= bw_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/base64_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// Top level of the base64 stream decoder: classifier, queue and decode engine.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.

// Decodes one base64 character per clock while the output is not stalled,
// giving exactly one result per character. A character is taken into a
// two-entry queue and, once the output register is free or being emptied,
// is decoded from the queue into the output register that offers the result;
// the combinational update of the bit accumulator, counters and end-of-string
// status in the decode engine sets the rate of one character per clock. The
// queue and the output register let either side stall without losing
// transfers. The result with tlast set carries the status and count; the
// consumer discards the bytes of a string whose status is non-zero. Write
// the capacity register only while idle.
module base64_stream_decoder_top #(
  parameter int unsigned MAX_INPUT_CHARS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // output_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] symbol
  input  logic        s_axis_tlast,    // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [7:0] data_byte, [9:8] status, [25:10] byte_count
  output logic        m_axis_tlast,    // done_res
  output logic        m_axis_tuser     // byte_valid
);
  import b64d_pkg::*;

  localparam int unsigned CharW = $clog2(MAX_INPUT_CHARS + 2);

  b64d_qstat_t qstat;
  b64d_sym_t   q_wdata, q_rdata;
  logic        push, pop;
  b64d_res_t   res;

  b64d_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .qstat_i         (qstat),
    .push_o          (push),
    .entry_o         (q_wdata)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .stat_o  (qstat)
  );

  b64d_back #(
    .MaxChars (MAX_INPUT_CHARS),
    .Cw       (CharW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .qstat_i     (qstat),
    .entry_i     (q_rdata),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result item
  assign m_axis_tdata = {6'b0, res.byte_count, res.status, res.data_byte};
  assign m_axis_tlast = res.done_res;
  assign m_axis_tuser = res.byte_valid;

`ifndef SYNTHESIS
  // Input back-pressure only follows an output stall
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // Status and count stay clear away from the end of a string
  a_mid_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[25:8] == 18'd0)
    else $error("status or count set before the last character");

  // Only an ok or too-small status carries a count
  a_err_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast &&
    (m_axis_tdata[9:8] == StBadLen || m_axis_tdata[9:8] == StBadChar)
    |-> m_axis_tdata[25:10] == 16'd0)
    else $error("count reported with an error status");
`endif

endmodule
